[hw/rtl/inline_color_code_text_parser_assert.svh]
// Assertion macros used by the port-level checker of the inline color code text parser.
`ifndef INLINE_COLOR_CODE_TEXT_PARSER_ASSERT_SVH
`define INLINE_COLOR_CODE_TEXT_PARSER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define ICCTP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ICCTP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

[hw/rtl/icctp_pkg.sv]
// Shared types, constants and helper functions of the inline color code text parser.
`default_nettype none
package icctp_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [0:0] REG_COLORED_TEXT = 1'b0;

    localparam logic [7:0] CH_AMP = 8'h26;
    localparam logic [7:0] CH_C   = 8'h63;
    localparam logic [7:0] CH_R   = 8'h72;
    localparam logic [7:0] CH_MAX = 8'hff;

    localparam int MAX_HELD = 4;
    localparam int HELD_IDX_W = $clog2(MAX_HELD);

    typedef enum logic [1:0] {
        MAIN_NONE,
        MAIN_GLYPH,
        MAIN_COLOR
    } main_kind_t;

    typedef struct packed {
        logic       load;
        logic       emit;
        logic [2:0] idx;
        logic       last;
    } icctp_cmd_t;

    typedef struct packed {
        logic       out_free;
        logic [3:0] total;
    } icctp_sts_t;

    function automatic logic is_hex(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [3:0] v;
        if (c inside {[8'h30:8'h39]}) begin
            v = c[3:0];
        end else begin
            v = c[3:0] + 4'd9;
        end
        return v;
    endfunction

endpackage
`default_nettype wire

[hw/rtl/icctp_ctrl.sv]
// Controller that accepts items and sequences their results one per cycle while the output is free.
`default_nettype none
module icctp_ctrl (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire icctp_pkg::icctp_sts_t  sts,
    output icctp_pkg::icctp_cmd_t       cmd
);
    import icctp_pkg::*;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t     state_reg;
    logic [2:0] idx_reg;
    logic       last;

    assign last    = (({1'b0, idx_reg} + 4'd1) == sts.total);
    assign s_ready = (state_reg == ST_IDLE);

    assign cmd.load = s_valid && (state_reg == ST_IDLE);
    assign cmd.emit = (state_reg == ST_RUN) && (sts.total != 4'd0) && sts.out_free;
    assign cmd.idx  = idx_reg;
    assign cmd.last = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= 3'd0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg <= ST_RUN;
                        idx_reg   <= 3'd0;
                    end
                end
                ST_RUN: begin
                    if (sts.total == 4'd0) begin
                        state_reg <= ST_IDLE;
                    end else if (sts.out_free) begin
                        idx_reg <= idx_reg + 3'd1;
                        if (last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hw/rtl/icctp_dp.sv]
// Datapath that parses each byte, holds escape state and drives the result register.
`default_nettype none
module icctp_dp (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire icctp_pkg::icctp_cmd_t  cmd,
    output icctp_pkg::icctp_sts_t       sts,
    input  wire logic                   colored_text,
    input  wire logic [7:0]             s_text_byte,
    input  wire logic                   s_string_end,
    input  wire logic                   s_alt_red,
    input  wire logic [7:0]             s_alpha_level,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic                        m_kind,
    output logic [7:0]                  m_glyph_code,
    output logic [7:0]                  m_color_red,
    output logic [7:0]                  m_color_green,
    output logic [7:0]                  m_color_blue,
    output logic [7:0]                  m_color_alpha,
    output logic                        m_run_last
);
    import icctp_pkg::*;

    logic [2:0]            held_count_reg;
    logic [7:0]            held_bytes_reg [MAX_HELD];
    logic                  is_white_reg;
    logic                  color_seen_reg;

    logic [7:0]            byte_reg;
    logic                  red_mask_reg;
    main_kind_t            main_reg;
    logic [7:0]            col_red_reg;
    logic [7:0]            col_green_reg;
    logic [7:0]            col_blue_reg;
    logic [7:0]            col_alpha_reg;
    logic [2:0]            f1_reg;
    logic [2:0]            f2_reg;
    logic                  white_reg;

    logic [2:0]            held_count_next;
    logic [2:0]            hc_parse;
    logic                  is_white_next;
    logic                  color_seen_next;
    main_kind_t            main_next;
    logic [7:0]            col_red_next;
    logic [7:0]            col_green_next;
    logic [7:0]            col_blue_next;
    logic [2:0]            f1_next;
    logic [2:0]            f2_next;
    logic                  fresh;
    logic                  hold_we;
    logic [HELD_IDX_W-1:0] hold_idx;

    logic                  m_valid_reg;
    logic                  m_kind_reg;
    logic [7:0]            m_glyph_reg;
    logic [7:0]            m_red_reg;
    logic [7:0]            m_green_reg;
    logic [7:0]            m_blue_reg;
    logic [7:0]            m_alpha_reg;
    logic                  m_last_reg;

    logic [3:0]            s1;
    logic [3:0]            s2;
    logic [3:0]            total;
    logic [3:0]            ri;
    logic [3:0]            ri_off;
    logic [HELD_IDX_W-1:0] rd_idx;
    logic [7:0]            rd_byte;
    logic                  r_kind;
    logic [7:0]            r_glyph;
    logic [7:0]            r_red;
    logic [7:0]            r_green;
    logic [7:0]            r_blue;
    logic [7:0]            r_alpha;

    always_comb begin
        hc_parse        = held_count_reg;
        is_white_next   = is_white_reg;
        color_seen_next = color_seen_reg;
        main_next       = MAIN_NONE;
        col_red_next    = CH_MAX;
        col_green_next  = CH_MAX;
        col_blue_next   = CH_MAX;
        f1_next         = 3'd0;
        fresh           = 1'b0;
        hold_we         = 1'b0;
        hold_idx        = '0;
        case (held_count_reg)
            3'd0: begin
                fresh = 1'b1;
            end
            3'd1: begin
                if (s_text_byte == CH_C) begin
                    hold_we  = 1'b1;
                    hold_idx = HELD_IDX_W'(1);
                    hc_parse = 3'd2;
                end else if (s_text_byte == CH_R) begin
                    hc_parse = 3'd0;
                    if (!is_white_reg) begin
                        is_white_next = 1'b1;
                        if (colored_text) begin
                            main_next = MAIN_COLOR;
                        end
                    end
                end else begin
                    f1_next = 3'd1;
                    fresh   = 1'b1;
                end
            end
            default: begin
                if (is_hex(s_text_byte)) begin
                    if (!held_count_reg[2]) begin
                        hold_we  = 1'b1;
                        hold_idx = held_count_reg[HELD_IDX_W-1:0];
                        hc_parse = held_count_reg + 3'd1;
                    end else begin
                        hc_parse        = 3'd0;
                        color_seen_next = 1'b1;
                        if (colored_text) begin
                            is_white_next  = 1'b0;
                            main_next      = MAIN_COLOR;
                            col_red_next   = {hex_val(held_bytes_reg[2]), 4'd0};
                            col_green_next = {hex_val(held_bytes_reg[3]), 4'd0};
                            col_blue_next  = {hex_val(s_text_byte), 4'd0};
                        end
                    end
                end else begin
                    f1_next = held_count_reg;
                    fresh   = 1'b1;
                end
            end
        endcase
        if (fresh) begin
            if (s_text_byte == CH_AMP) begin
                hold_we  = 1'b1;
                hold_idx = '0;
                hc_parse = 3'd1;
            end else begin
                hc_parse  = 3'd0;
                main_next = MAIN_GLYPH;
            end
        end
        held_count_next = hc_parse;
        f2_next         = 3'd0;
        if (s_string_end) begin
            f2_next         = hc_parse;
            held_count_next = 3'd0;
            is_white_next   = 1'b1;
            color_seen_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_count_reg <= 3'd0;
            is_white_reg   <= 1'b1;
            color_seen_reg <= 1'b0;
        end else if (cmd.load) begin
            held_count_reg <= held_count_next;
            is_white_reg   <= is_white_next;
            color_seen_reg <= color_seen_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            if (hold_we) begin
                held_bytes_reg[hold_idx] <= s_text_byte;
            end
            byte_reg      <= s_text_byte;
            red_mask_reg  <= s_alt_red && !color_seen_reg;
            main_reg      <= main_next;
            col_red_reg   <= col_red_next;
            col_green_reg <= col_green_next;
            col_blue_reg  <= col_blue_next;
            col_alpha_reg <= s_alpha_level;
            f1_reg        <= f1_next;
            f2_reg        <= f2_next;
            white_reg     <= s_string_end;
        end
    end

    assign s1     = {1'b0, f1_reg} + ((main_reg != MAIN_NONE) ? 4'd1 : 4'd0);
    assign s2     = s1 + {1'b0, f2_reg};
    assign total  = s2 + {3'd0, white_reg};
    assign ri     = {1'b0, cmd.idx};
    assign ri_off = ri - s1;
    assign rd_idx = (ri < {1'b0, f1_reg}) ? ri[HELD_IDX_W-1:0] : ri_off[HELD_IDX_W-1:0];
    assign rd_byte = held_bytes_reg[rd_idx];

    always_comb begin
        r_kind  = 1'b1;
        r_glyph = 8'd0;
        r_red   = CH_MAX;
        r_green = CH_MAX;
        r_blue  = CH_MAX;
        r_alpha = CH_MAX;
        if ((ri < {1'b0, f1_reg}) || ((ri >= s1) && (ri < s2))) begin
            r_kind  = 1'b0;
            r_glyph = rd_byte | {red_mask_reg, 7'd0};
            r_red   = 8'd0;
            r_green = 8'd0;
            r_blue  = 8'd0;
            r_alpha = 8'd0;
        end else if (ri < s1) begin
            if (main_reg == MAIN_GLYPH) begin
                r_kind  = 1'b0;
                r_glyph = byte_reg | {red_mask_reg, 7'd0};
                r_red   = 8'd0;
                r_green = 8'd0;
                r_blue  = 8'd0;
                r_alpha = 8'd0;
            end else begin
                r_red   = col_red_reg;
                r_green = col_green_reg;
                r_blue  = col_blue_reg;
                r_alpha = col_alpha_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_kind_reg  <= r_kind;
            m_glyph_reg <= r_glyph;
            m_red_reg   <= r_red;
            m_green_reg <= r_green;
            m_blue_reg  <= r_blue;
            m_alpha_reg <= r_alpha;
            m_last_reg  <= cmd.last;
        end
    end

    assign sts.out_free = !m_valid_reg || m_ready;
    assign sts.total    = total;

    assign m_valid       = m_valid_reg;
    assign m_kind        = m_kind_reg;
    assign m_glyph_code  = m_glyph_reg;
    assign m_color_red   = m_red_reg;
    assign m_color_green = m_green_reg;
    assign m_color_blue  = m_blue_reg;
    assign m_color_alpha = m_alpha_reg;
    assign m_run_last    = m_last_reg;

endmodule
`default_nettype wire

[hw/rtl/inline_color_code_text_parser.sv]
// Top level of the inline color code text parser with its configuration register port.
// An item is accepted only while the controller is idle; its results then leave one per cycle
// from the output register while it is free, and no new item is taken until the last is loaded.
// A failed escape at the end of a string gives up to six results; output stalls hold the flow.
// Synchronous active-low reset clears the pending escape, sets the color to white, clears
// the color-seen flag, drops the output valid and sets colored_text to one.
`default_nettype none
module inline_color_code_text_parser (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic                             s_valid,
    output logic                                  s_ready,
    input  wire logic [7:0]                       s_text_byte,
    input  wire logic                             s_string_end,
    input  wire logic                             s_alt_red,
    input  wire logic [7:0]                       s_alpha_level,
    output logic                                  m_valid,
    input  wire logic                             m_ready,
    output logic                                  m_kind,
    output logic [7:0]                            m_glyph_code,
    output logic [7:0]                            m_color_red,
    output logic [7:0]                            m_color_green,
    output logic [7:0]                            m_color_blue,
    output logic [7:0]                            m_color_alpha,
    output logic                                  m_run_last,
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [icctp_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [icctp_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [icctp_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                  pready
);
    import icctp_pkg::*;

    icctp_cmd_t cmd;
    icctp_sts_t sts;
    logic       colored_text_reg;
    logic       reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[CFG_ADDR_W-1:2] == REG_COLORED_TEXT);
    assign prdata  = reg_sel ? {{(CFG_DATA_W-1){1'b0}}, colored_text_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            colored_text_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && reg_sel) begin
            colored_text_reg <= pwdata[0];
        end
    end

    icctp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    icctp_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .colored_text  (colored_text_reg),
        .s_text_byte   (s_text_byte),
        .s_string_end  (s_string_end),
        .s_alt_red     (s_alt_red),
        .s_alpha_level (s_alpha_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_glyph_code  (m_glyph_code),
        .m_color_red   (m_color_red),
        .m_color_green (m_color_green),
        .m_color_blue  (m_color_blue),
        .m_color_alpha (m_color_alpha),
        .m_run_last    (m_run_last)
    );

endmodule
`default_nettype wire

[hw/rtl/icctp_checker.sv]
// Port-level checker for the inline color code text parser and its bind statement.
`default_nettype none
`include "inline_color_code_text_parser_assert.svh"
module icctp_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       s_valid,
    input wire logic       s_ready,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic       m_kind,
    input wire logic [7:0] m_glyph_code,
    input wire logic [7:0] m_color_red,
    input wire logic [7:0] m_color_green,
    input wire logic [7:0] m_color_blue,
    input wire logic [7:0] m_color_alpha,
    input wire logic       m_run_last,
    input wire logic       pready
);

    logic [49:0] m_payload;
    logic [7:0]  m_color_any;
    logic        out_stall;

    assign m_payload   = {m_kind, m_glyph_code, m_color_red, m_color_green, m_color_blue,
                          m_color_alpha, m_run_last};
    assign m_color_any = m_color_red | m_color_green | m_color_blue | m_color_alpha;
    assign out_stall   = m_valid && !m_ready;

    `ICCTP_ASSERT(a_out_hold, out_stall |=> m_valid && $stable(m_payload), "stalled result changed")
    `ICCTP_ASSERT(a_color_no_glyph, m_valid && m_kind |-> m_glyph_code == 8'd0, "glyph on color")
    `ICCTP_ASSERT(a_glyph_no_color, m_valid && !m_kind |-> m_color_any == 8'd0, "color on glyph")
    `ICCTP_ASSERT(a_busy_after_accept, s_valid && s_ready |=> !s_ready, "item taken while busy")
    `ICCTP_ASSERT_ALWAYS(a_pready_high, pready, "configuration port stalled")

endmodule

bind inline_color_code_text_parser icctp_checker u_icctp_checker (.*);
`default_nettype wire

[bench/text_result_checker.sv]
// Checker that predicts the parser's glyph and color results and compares them as they leave.
module text_result_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic [7:0]                       s_text_byte,
    input  logic                             s_string_end,
    input  logic                             s_alt_red,
    input  logic [7:0]                       s_alpha_level,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic                             m_kind,
    input  logic [7:0]                       m_glyph_code,
    input  logic [7:0]                       m_color_red,
    input  logic [7:0]                       m_color_green,
    input  logic [7:0]                       m_color_blue,
    input  logic [7:0]                       m_color_alpha,
    input  logic                             m_run_last,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic                             pready,
    input  logic [icctp_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [icctp_pkg::CFG_DATA_W-1:0] pwdata,
    output int                               errors,
    output int                               waiting,
    output int                               checked
);
    import icctp_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] ADDR_COLORED_TEXT = CFG_ADDR_W'(4 * REG_COLORED_TEXT);
    localparam logic                  KIND_GLYPH = 1'b0;
    localparam logic                  KIND_COLOR = 1'b1;
    localparam int                    MAX_RESULTS = 6;

    typedef struct packed {
        logic       kind;
        logic [7:0] glyph;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } text_res_t;

    logic       colored;
    logic [2:0] held_n;
    logic [7:0] held [4];
    logic       white;
    logic       seen;
    logic       red_set;
    text_res_t  item_results[$];
    text_res_t  pending_results[$];

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            return {1'b1, 4'(c - "a" + 10)};
        end else if (c >= "A" && c <= "F") begin
            return {1'b1, 4'(c - "A" + 10)};
        end
        return 5'd0;
    endfunction

    task automatic add_result(input logic k, input logic [7:0] g, input logic [7:0] r,
                              input logic [7:0] gr, input logic [7:0] b, input logic [7:0] a);
        text_res_t res;
        res = '{k, g, r, gr, b, a, 1'b0};
        if (item_results.size() < MAX_RESULTS) begin
            item_results.push_back(res);
        end
    endtask

    task automatic add_glyph(input logic [7:0] c);
        add_result(KIND_GLYPH, (red_set && !seen) ? (c | 8'h80) : c, 8'd0, 8'd0, 8'd0, 8'd0);
    endtask

    task automatic flush_held();
        for (int k = 0; k < held_n; k++) begin
            add_glyph(held[k]);
        end
        held_n = 3'd0;
    endtask

    task automatic start_fresh(input logic [7:0] b);
        if (b == CH_AMP) begin
            held[0] = b;
            held_n = 3'd1;
        end else begin
            add_glyph(b);
        end
    endtask

    task automatic parse_text_byte(input logic [7:0] b, input logic [7:0] alpha);
        logic [4:0] dig;
        logic [4:0] dig_r;
        logic [4:0] dig_g;
        dig = hex_digit(b);
        if (held_n == 3'd0) begin
            start_fresh(b);
        end else if (held_n == 3'd1) begin
            if (b == CH_C) begin
                held[1] = b;
                held_n = 3'd2;
            end else if (b == CH_R) begin
                held_n = 3'd0;
                if (!white) begin
                    white = 1'b1;
                    if (colored) begin
                        add_result(KIND_COLOR, 8'd0, CH_MAX, CH_MAX, CH_MAX, alpha);
                    end
                end
            end else begin
                flush_held();
                start_fresh(b);
            end
        end else if (dig[4]) begin
            if (held_n < 3'd4) begin
                held[held_n[1:0]] = b;
                held_n = held_n + 3'd1;
            end else begin
                held_n = 3'd0;
                seen = 1'b1;
                if (colored) begin
                    white = 1'b0;
                    dig_r = hex_digit(held[2]);
                    dig_g = hex_digit(held[3]);
                    add_result(KIND_COLOR, 8'd0, {dig_r[3:0], 4'h0},
                               {dig_g[3:0], 4'h0}, {dig[3:0], 4'h0}, alpha);
                end
            end
        end else begin
            flush_held();
            start_fresh(b);
        end
    endtask

    task automatic predict_item();
        item_results.delete();
        red_set = s_alt_red;
        parse_text_byte(s_text_byte, s_alpha_level);
        if (s_string_end) begin
            flush_held();
            add_result(KIND_COLOR, 8'd0, CH_MAX, CH_MAX, CH_MAX, CH_MAX);
            white = 1'b1;
            seen = 1'b0;
        end
        if (item_results.size() > 0) begin
            item_results[item_results.size() - 1].last = 1'b1;
        end
        foreach (item_results[i]) begin
            pending_results.push_back(item_results[i]);
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("checker: result %0d: %s", checked, msg);
        errors++;
    endtask

    task automatic check_result();
        text_res_t got;
        text_res_t want;
        got = '{m_kind, m_glyph_code, m_color_red, m_color_green, m_color_blue,
                m_color_alpha, m_run_last};
        if (pending_results.size() == 0) begin
            report_mismatch($sformatf("unexpected result %h", got));
        end else begin
            want = pending_results.pop_front();
            if (got.kind !== want.kind)
                report_mismatch($sformatf("kind %0h, expected %0h", got.kind, want.kind));
            if (got.glyph !== want.glyph)
                report_mismatch($sformatf("glyph %0h, expected %0h", got.glyph, want.glyph));
            if (got.red !== want.red)
                report_mismatch($sformatf("red %0h, expected %0h", got.red, want.red));
            if (got.green !== want.green)
                report_mismatch($sformatf("green %0h, expected %0h", got.green, want.green));
            if (got.blue !== want.blue)
                report_mismatch($sformatf("blue %0h, expected %0h", got.blue, want.blue));
            if (got.alpha !== want.alpha)
                report_mismatch($sformatf("alpha %0h, expected %0h", got.alpha, want.alpha));
            if (got.last !== want.last)
                report_mismatch($sformatf("run_last %0h, expected %0h", got.last, want.last));
        end
        checked++;
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            colored = 1'b1;
            held_n = 3'd0;
            white = 1'b1;
            seen = 1'b0;
            pending_results.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_COLORED_TEXT) begin
                colored = pwdata[0];
            end
            if (s_valid && s_ready) begin
                predict_item();
            end
            if (m_valid && m_ready) begin
                check_result();
            end
        end
        waiting = pending_results.size();
    end

endmodule

[bench/tb.sv]
// Testbench top that feeds text strings and settings to the parser and reports the verdict.
module tb;
    import icctp_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] ADDR_COLORED_TEXT = CFG_ADDR_W'(4 * REG_COLORED_TEXT);
    localparam int PHASE_ITEMS = 57;
    localparam int RANDOM_PHASES = 4;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [7:0]            s_text_byte = 8'h20;
    logic                  s_string_end = 1'b0;
    logic                  s_alt_red = 1'b0;
    logic [7:0]            s_alpha_level = 8'h00;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic                  m_kind;
    logic [7:0]            m_glyph_code;
    logic [7:0]            m_color_red;
    logic [7:0]            m_color_green;
    logic [7:0]            m_color_blue;
    logic [7:0]            m_color_alpha;
    logic                  m_run_last;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    int   errors;
    int   waiting;
    int   checked;
    int   n_items = 0;
    int   n_strings = 0;
    int   n_settings = 0;
    int   out_hold = 0;
    logic no_idle = 1'b0;

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    inline_color_code_text_parser u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_string_end  (s_string_end),
        .s_alt_red     (s_alt_red),
        .s_alpha_level (s_alpha_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_glyph_code  (m_glyph_code),
        .m_color_red   (m_color_red),
        .m_color_green (m_color_green),
        .m_color_blue  (m_color_blue),
        .m_color_alpha (m_color_alpha),
        .m_run_last    (m_run_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    text_result_checker u_check (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .s_string_end  (s_string_end),
        .s_alt_red     (s_alt_red),
        .s_alpha_level (s_alpha_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_kind        (m_kind),
        .m_glyph_code  (m_glyph_code),
        .m_color_red   (m_color_red),
        .m_color_green (m_color_green),
        .m_color_blue  (m_color_blue),
        .m_color_alpha (m_color_alpha),
        .m_run_last    (m_run_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .pready        (pready),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .errors        (errors),
        .waiting       (waiting),
        .checked       (checked)
    );

    // The receiver drops m_ready after each result it sees, at random and never while no_idle is set.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            out_hold = 0;
        end else if (out_hold > 0) begin
            m_ready <= 1'b0;
            out_hold--;
        end else begin
            m_ready <= 1'b1;
            if (m_valid) begin
                out_hold = no_idle ? 0 : $urandom_range(0, 3);
            end
        end
    end

    task automatic send_item(input logic [7:0] b, input logic last, input logic red,
                             input logic [7:0] alpha);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_text_byte <= b;
        s_string_end <= last;
        s_alt_red <= red;
        s_alpha_level <= alpha;
        @(posedge aclk);
        while (s_ready !== 1'b1) @(posedge aclk);
        @(negedge aclk);
        n_items++;
    endtask

    task automatic send_str(input string txt, input logic red, input logic [7:0] alpha);
        for (int i = 0; i < txt.len(); i++) begin
            send_item(txt[i], i == txt.len() - 1, red, alpha);
        end
        n_strings++;
    endtask

    function automatic logic [7:0] pick_hex();
        string digits;
        digits = "0123456789abcdefABCDEF";
        return digits[$urandom_range(0, 21)];
    endfunction

    // Well-formed escapes with random content, mixed with plain bytes and broken escapes.
    task automatic send_random_string();
        logic [7:0] txt[$];
        logic       red;
        logic [7:0] alpha;
        int         len;
        len = $urandom_range(1, 10);
        red = 1'($urandom_range(0, 1));
        alpha = 8'($urandom_range(0, 255));
        no_idle = ($urandom_range(0, 5) == 0);
        while (txt.size() < len) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: begin
                    txt.push_back(8'($urandom_range(1, 255)));
                end
                4, 5, 6: begin
                    txt.push_back(CH_AMP);
                    txt.push_back(CH_C);
                    repeat (3) txt.push_back(pick_hex());
                end
                7: begin
                    txt.push_back(CH_AMP);
                    txt.push_back(CH_R);
                end
                8: begin
                    txt.push_back(CH_AMP);
                    txt.push_back(8'($urandom_range(1, 255)));
                end
                default: begin
                    txt.push_back(CH_AMP);
                    txt.push_back(CH_C);
                    repeat ($urandom_range(0, 2)) txt.push_back(pick_hex());
                    txt.push_back(8'($urandom_range(1, 255)));
                end
            endcase
        end
        foreach (txt[k]) begin
            send_item(txt[k], k == txt.size() - 1, red,
                      ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) : alpha);
        end
        n_strings++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (waiting != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic write_colored(input logic value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_COLORED_TEXT;
        pwdata <= CFG_DATA_W'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (pready !== 1'b1) @(posedge aclk);
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        n_settings++;
    endtask

    initial begin
        int base;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        send_item(8'h01, 1'b0, 1'b0, 8'h00);
        send_item(8'hff, 1'b0, 1'b1, 8'hff);
        send_str("q&c9Bfw&r&r", 1'b1, 8'h7f);
        send_str("&x&cg&c12&", 1'b0, 8'h40);
        settle();
        write_colored(1'b0);
        send_str("&c1A3z&r", 1'b1, 8'h55);

        base = n_items;
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            settle();
            write_colored(ph % 2 == 0);
            while (n_items < base + PHASE_ITEMS * (ph + 1)) send_random_string();
        end

        settle();
        repeat (20) @(negedge aclk);
        $display("Sent %0d text bytes in %0d strings under %0d register settings.",
                 n_items, n_strings, n_settings);
        $display("Compared %0d results against the prediction.", checked);
        if (errors == 0 && waiting == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("tb NOT OK");
        $finish;
    end

endmodule
